FILE: sv/scfp_pkg.sv
// Shared types and constants for the signed coordinate frame parser.
`default_nettype none
package scfp_pkg;

  // Frame delimiter bytes (ASCII)
  localparam logic [7:0] CH_START = 8'h40;  // '@'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_SEP   = 8'h3A;  // ':'
  localparam logic [7:0] CH_END   = 8'h24;  // '$'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_XFIRST = 3'd1,
    PH_XDIG   = 3'd2,
    PH_YFIRST = 3'd3,
    PH_YDIG   = 3'd4,
    PH_SKIP   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_START = 3'd1,
    ST_NOSEP = 3'd2,
    ST_DIGIT = 3'd3,
    ST_OVFL  = 3'd4
  } status_e;

endpackage
`default_nettype wire

FILE: sv/scfp_digit_acc.sv
// Decimal digit append (mag*10 + digit) with signed-range overflow check.
`default_nettype none
module scfp_digit_acc #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic [VALUE_WIDTH-1:0] mag_i,
  input  logic [3:0]             digit_i,
  output logic [VALUE_WIDTH-1:0] mag_o,
  output logic                   ovfl_o
);

  localparam int WW = VALUE_WIDTH + 4;
  // Largest positive magnitude: 2^(W-1)-1
  localparam logic [WW-1:0] MagLimit = {5'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic [WW-1:0] mag_ext;
  logic [WW-1:0] sum;

  // x*10 = x*8 + x*2
  assign mag_ext = {4'b0, mag_i};
  assign sum     = (mag_ext << 3) + (mag_ext << 1) + {{(WW-4){1'b0}}, digit_i};
  assign ovfl_o  = (sum > MagLimit);
  assign mag_o   = sum[VALUE_WIDTH-1:0];

endmodule
`default_nettype wire

FILE: sv/signed_coordinate_frame_parser.sv
// Top level: byte-stream parser for '@' [-]x ':' [-]y '$' coordinate frames.
`default_nettype none
// Accepts one ASCII byte per transaction on the input channel and emits one
// result transaction (x, y, status) for every '$' byte. Frames look like
// '@' [-]digits ':' [-]digits '$'; any byte after a '$' or after reset opens
// a new frame. Status: 0 ok, 1 bad start byte, 2 '$' before the ':'
// separator, 3 unexpected byte where a digit was due, 4 magnitude above
// 2^(VALUE_WIDTH-1)-1 (so the most negative value also counts as overflow).
// The first error in a frame wins; the rest of the frame is skipped up to
// its '$', and x/y read as zero on any error. Empty fields read as zero.
// Throughput: one byte per clock. Each byte's parse step (phase update,
// one multiply-by-ten-plus-digit shared by both fields) completes in the
// accepting cycle; a '$' result is captured in an output register.
// The input stays ready while that register is empty or being drained, so a
// full-rate stream is sustained whenever the consumer keeps out_ready_i high.
module signed_coordinate_frame_parser #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] x_value_o,
  output logic signed [VALUE_WIDTH-1:0] y_value_o,
  output logic [2:0]                    frame_status_o
);

  import scfp_pkg::*;

  // Parse state
  phase_e                 phase_q, phase_d;
  logic [VALUE_WIDTH-1:0] x_mag_q, x_mag_d;
  logic [VALUE_WIDTH-1:0] y_mag_q, y_mag_d;
  logic                   x_neg_q, x_neg_d;
  logic                   y_neg_q, y_neg_d;
  status_e                err_q, err_d;

  // Result register
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] x_out_q, x_out_d;
  logic [VALUE_WIDTH-1:0] y_out_q, y_out_d;
  status_e                st_out_q, st_out_d;

  logic                   in_accept;
  logic                   emit;
  logic                   is_digit;
  logic                   in_y;
  logic [VALUE_WIDTH-1:0] acc_mag_in;
  logic [VALUE_WIDTH-1:0] acc_mag_out;
  logic                   acc_ovfl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_digit   = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);

  // One accumulator serves whichever field is currently being parsed
  assign in_y       = (phase_q == PH_YFIRST) || (phase_q == PH_YDIG);
  assign acc_mag_in = in_y ? y_mag_q : x_mag_q;

  scfp_digit_acc #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_acc (
    .mag_i  (acc_mag_in),
    .digit_i(rx_byte_i[3:0]),
    .mag_o  (acc_mag_out),
    .ovfl_o (acc_ovfl)
  );

  always_comb begin
    phase_d  = phase_q;
    x_mag_d  = x_mag_q;
    y_mag_d  = y_mag_q;
    x_neg_d  = x_neg_q;
    y_neg_d  = y_neg_q;
    err_d    = err_q;
    emit     = 1'b0;
    st_out_d = ST_OK;
    x_out_d  = '0;
    y_out_d  = '0;

    if (rx_byte_i == CH_END) begin
      // End of frame: report and start over
      emit = 1'b1;
      unique case (phase_q)
        PH_IDLE:              st_out_d = ST_START;
        PH_XFIRST, PH_XDIG:   st_out_d = ST_NOSEP;
        PH_YFIRST, PH_YDIG:   st_out_d = ST_OK;
        default:              st_out_d = err_q;
      endcase
      if (st_out_d == ST_OK) begin
        x_out_d = x_neg_q ? VALUE_WIDTH'(~x_mag_q + 1'b1) : x_mag_q;
        y_out_d = y_neg_q ? VALUE_WIDTH'(~y_mag_q + 1'b1) : y_mag_q;
      end
      phase_d = PH_IDLE;
      x_mag_d = '0;
      y_mag_d = '0;
      x_neg_d = 1'b0;
      y_neg_d = 1'b0;
      err_d   = ST_OK;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == CH_START) begin
            phase_d = PH_XFIRST;
          end else begin
            phase_d = PH_SKIP;
            err_d   = ST_START;
          end
        end
        PH_XFIRST, PH_XDIG: begin
          if (rx_byte_i == CH_SEP) begin
            phase_d = PH_YFIRST;
          end else if (phase_q == PH_XFIRST && rx_byte_i == CH_MINUS) begin
            x_neg_d = 1'b1;
            phase_d = PH_XDIG;
          end else if (is_digit) begin
            if (acc_ovfl) begin
              phase_d = PH_SKIP;
              err_d   = ST_OVFL;
            end else begin
              phase_d = PH_XDIG;
              x_mag_d = acc_mag_out;
            end
          end else begin
            phase_d = PH_SKIP;
            err_d   = ST_DIGIT;
          end
        end
        PH_YFIRST, PH_YDIG: begin
          if (phase_q == PH_YFIRST && rx_byte_i == CH_MINUS) begin
            y_neg_d = 1'b1;
            phase_d = PH_YDIG;
          end else if (is_digit) begin
            if (acc_ovfl) begin
              phase_d = PH_SKIP;
              err_d   = ST_OVFL;
            end else begin
              phase_d = PH_YDIG;
              y_mag_d = acc_mag_out;
            end
          end else begin
            phase_d = PH_SKIP;
            err_d   = ST_DIGIT;
          end
        end
        default: begin
          // skipping the remainder of an errored frame
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      x_mag_q <= '0;
      y_mag_q <= '0;
      x_neg_q <= 1'b0;
      y_neg_q <= 1'b0;
      err_q   <= ST_OK;
    end else if (in_accept) begin
      phase_q <= phase_d;
      x_mag_q <= x_mag_d;
      y_mag_q <= y_mag_d;
      x_neg_q <= x_neg_d;
      y_neg_q <= y_neg_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      x_out_q  <= x_out_d;
      y_out_q  <= y_out_d;
      st_out_q <= st_out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign x_value_o      = x_out_q;
  assign y_value_o      = y_out_q;
  assign frame_status_o = st_out_q;

  // A failed frame never reports coordinates
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o != ST_OK) |-> (x_value_o == '0) && (y_value_o == '0))
    else $error("nonzero coordinates on errored frame");

  // Good frames never carry the most negative value (reported as overflow)
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == ST_OK) |->
      (x_value_o != {1'b1, {(VALUE_WIDTH-1){1'b0}}}) &&
      (y_value_o != {1'b1, {(VALUE_WIDTH-1){1'b0}}}))
    else $error("most negative value reported as ok");

  // Skipping always carries a recorded error
  a_skip_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (err_q != ST_OK))
    else $error("skip phase without error mark");

  // Every accepted '$' restarts the frame and produces a result
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (rx_byte_i == CH_END) |=> (phase_q == PH_IDLE) && out_valid_q &&
      (x_mag_q == '0) && (y_mag_q == '0))
    else $error("frame end did not restart parser");

  // An empty result register never stalls the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire

FILE: test/signed_coordinate_frame_parser_tb.sv
// Self-checking testbench for the signed coordinate frame parser.
`default_nettype none
// Bytes go in as valid/ready transactions and every '$' byte must produce one
// (x, y, status) transaction. A predictor in this file parses the same byte
// stream and queues the expected frames; a checker on the output side pops
// them in order and compares each field.
//
// Test sequence:
//   directed frames - field extremes, empty fields, every error status,
//                     first-error-wins, leading zeros, bytes 0x00 and 0xFF
//   random frames   - mostly well-formed frames with random content, some
//                     with one injected flaw, plus stretches of raw noise
//   pattern stalls  - receiver follows a fixed rotating ready pattern
//   full rate       - no sender gaps, receiver always ready
//   backpressure    - receiver holds off while the sender keeps offering
//                     bytes, so the input stalls
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scfp_pkg::*;

  localparam int VALUE_WIDTH = 32;
  localparam longint unsigned MAG_LIMIT = (64'd1 << (VALUE_WIDTH - 1)) - 1;
  localparam longint unsigned RADIX = 10;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_GUARD = 20000;  // cycles allowed for the tail to drain
  localparam int SETTLE_CYCLES = 10;   // idle time after the expected frames have drained

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] x;
    logic signed [VALUE_WIDTH-1:0] y;
    status_e                       status;
  } frame_result_t;

  // Receiver ready behavior
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_e;

  // DUT connections
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [7:0]                    rx_byte_i = 8'h00;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [VALUE_WIDTH-1:0] x_value_o;
  logic signed [VALUE_WIDTH-1:0] y_value_o;
  logic [2:0]                    frame_status_o;

  // Predictor state: mirrors the parser's frame state
  phase_e          parse_phase = PH_IDLE;
  longint unsigned x_mag = 0;
  longint unsigned y_mag = 0;
  bit              x_neg = 1'b0;
  bit              y_neg = 1'b0;
  status_e         first_error = ST_OK;

  frame_result_t expected_frames[$];  // frames still owed by the DUT

  int          error_count = 0;
  int          bytes_sent = 0;
  int          frames_checked = 0;
  bit          sender_gappy = 1'b1;  // insert random gaps between bursts
  int          burst_left = 0;
  ready_mode_e ready_mode = READY_RANDOM;
  int          hold_off_left = 0;    // receiver hold-off, counted down below
  logic [15:0] stall_pattern = 16'b1011_0111_0011_1101;

  signed_coordinate_frame_parser #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .x_value_o     (x_value_o),
    .y_value_o     (y_value_o),
    .frame_status_o(frame_status_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("** signed_coordinate_frame_parser: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_frame();
    parse_phase = PH_IDLE;
    x_mag       = 0;
    y_mag       = 0;
    x_neg       = 1'b0;
    y_neg       = 1'b0;
    first_error = ST_OK;
  endtask

  task automatic mark_error(input status_e code);
    first_error = code;
    parse_phase = PH_SKIP;
  endtask

  // Append one decimal digit; anything past the positive limit is overflow,
  // which also rules out the most negative value.
  task automatic append_digit(inout longint unsigned mag, input longint unsigned d);
    if (mag > (MAG_LIMIT - d) / RADIX) begin
      mark_error(ST_OVFL);
    end else begin
      mag = mag * RADIX + d;
    end
  endtask

  // Advance the predicted parse by one accepted byte; a '$' queues a frame.
  task automatic parse_byte(input logic [7:0] c);
    bit              is_digit;
    longint unsigned d;
    frame_result_t   r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d        = is_digit ? longint'(c - CH_ZERO) : 0;
    if (c == CH_END) begin
      case (parse_phase)
        PH_IDLE:              r.status = ST_START;  // '$' as the first byte
        PH_XFIRST, PH_XDIG:   r.status = ST_NOSEP;
        PH_YFIRST, PH_YDIG:   r.status = ST_OK;
        default:              r.status = first_error;
      endcase
      if (r.status == ST_OK) begin
        r.x = x_neg ? -x_mag[VALUE_WIDTH-1:0] : x_mag[VALUE_WIDTH-1:0];
        r.y = y_neg ? -y_mag[VALUE_WIDTH-1:0] : y_mag[VALUE_WIDTH-1:0];
      end else begin
        r.x = '0;
        r.y = '0;
      end
      expected_frames.push_back(r);
      clear_frame();
    end else begin
      case (parse_phase)
        PH_IDLE: begin
          if (c == CH_START) parse_phase = PH_XFIRST;
          else mark_error(ST_START);
        end
        PH_XFIRST, PH_XDIG: begin
          if (c == CH_SEP) begin
            parse_phase = PH_YFIRST;
          end else if (parse_phase == PH_XFIRST && c == CH_MINUS) begin
            x_neg       = 1'b1;
            parse_phase = PH_XDIG;
          end else if (is_digit) begin
            parse_phase = PH_XDIG;
            append_digit(x_mag, d);
          end else begin
            mark_error(ST_DIGIT);
          end
        end
        PH_YFIRST, PH_YDIG: begin
          if (parse_phase == PH_YFIRST && c == CH_MINUS) begin
            y_neg       = 1'b1;
            parse_phase = PH_YDIG;
          end else if (is_digit) begin
            parse_phase = PH_YDIG;
            append_digit(y_mag, d);
          end else begin
            mark_error(ST_DIGIT);
          end
        end
        default: ;  // skipping an errored frame up to its '$'
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one byte per input transaction, driven at the falling edge
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk_i);
    // Between bursts drop valid for a random gap; rx_byte wanders meanwhile
    // so a payload change without valid must be ignored.
    if (sender_gappy && burst_left == 0) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    if (burst_left > 0) burst_left--;
    // Hold valid and payload until the transaction is taken.
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern at the falling edge, checker at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      // Long hold-off: the output register fills and the input must stall.
      hold_off_left = hold_off_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready_i   <= stall_pattern[0];
          stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    frame_result_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected frame x=%0d y=%0d status=%0d",
                                  x_value_o, y_value_o, frame_status_o));
      end else begin
        r = expected_frames.pop_front();
        if (frame_status_o !== r.status)
          report_mismatch($sformatf("frame %0d: status %0d, expected %0d",
                                    frames_checked, frame_status_o, r.status));
        if (x_value_o !== r.x)
          report_mismatch($sformatf("frame %0d: x %0d, expected %0d",
                                    frames_checked, x_value_o, r.x));
        if (y_value_o !== r.y)
          report_mismatch($sformatf("frame %0d: y %0d, expected %0d",
                                    frames_checked, y_value_o, r.y));
      end
      frames_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Random frame generation
  // ---------------------------------------------------------------------------

  // Magnitudes weighted toward small values and the overflow boundary.
  function automatic longint unsigned pick_magnitude();
    case ($urandom_range(0, 9))
      0, 1, 2: return longint'($urandom_range(0, 999));
      3, 4:    return longint'($urandom >> 1);
      5:       return longint'($urandom);
      6:       return MAG_LIMIT - $urandom_range(0, 3);
      7:       return MAG_LIMIT + $urandom_range(1, 3);
      8:       return {$urandom, $urandom} >> $urandom_range(0, 40);
      default: return longint'($urandom_range(0, 9));
    endcase
  endfunction

  // A byte that does not belong where it lands: often a stray sign or
  // separator, otherwise anything at all.
  function automatic logic [7:0] stray_byte();
    case ($urandom_range(0, 2))
      0:       return CH_MINUS;
      1:       return CH_SEP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One numeric field: optional sign, optional leading zeros, digits; an
  // empty field now and then. With corrupt set, one stray byte goes in.
  task automatic send_field(input bit corrupt);
    string txt;
    int    zeros;
    int    stray_at;
    if ($urandom_range(0, 3) == 0) send_byte(CH_MINUS);
    if ($urandom_range(0, 11) == 0) begin
      txt = "";
    end else begin
      txt   = $sformatf("%0d", pick_magnitude());
      zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
      repeat (zeros) txt = {"0", txt};
    end
    stray_at = corrupt ? $urandom_range(0, txt.len()) : -1;
    for (int i = 0; i <= txt.len(); i++) begin
      if (i == stray_at) send_byte(stray_byte());
      if (i < txt.len()) send_byte(txt[i]);
    end
  endtask

  // Mostly clean frames; some get one flaw: bad start, stray byte in a
  // field, missing or wrong separator, or a second separator.
  task automatic send_random_frame();
    int flaw;
    flaw = $urandom_range(0, 15);
    if (flaw == 1) send_byte(8'($urandom_range(0, 255)));
    else send_byte(CH_START);
    send_field(flaw == 2);
    if (flaw == 4) send_byte(stray_byte());
    else if (flaw != 3) send_byte(CH_SEP);
    send_field(flaw == 5);
    if (flaw == 6) send_byte(CH_SEP);
    send_byte(CH_END);
  endtask

  // Raw noise: random bytes, usually closed by a '$' so a frame comes out.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) send_byte(CH_END);
  endtask

  task automatic send_random_mix(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_frames();
    ready_mode   = READY_RANDOM;
    sender_gappy = 1'b1;
    send_text("@0:0$");
    send_text("@-2147483647:2147483647$");  // both extremes that fit
    send_text("@2147483648:5$");            // x one past the limit
    send_text("@7:-2147483648$");           // most negative is overflow too
    send_text("@:$");                       // empty fields read as zero
    send_text("@-:$");
    send_text("@:-$");
    send_text("$");                         // '$' as first byte, result at once
    send_text("A12:3$");                    // wrong start byte
    send_byte(8'hFF);                       // top byte value as start byte
    send_text("1:2$");
    send_text("@12$");                      // '$' before the separator
    send_text("@1:2:3$");                   // second separator
    send_text("@4-2:1$");                   // sign inside the digits
    send_text("@1:");                       // zero byte where a digit is due
    send_byte(8'h00);
    send_text("$");
    send_text("@00000000000000000000042:-0009$");  // leading zeros are harmless
    send_text("@1x:99999999999$");          // first error wins over overflow
    send_text("@99999999999:1x$");          // and the other way around
  endtask

  task automatic test_random_frames();
    ready_mode   = READY_RANDOM;
    sender_gappy = 1'b1;
    send_random_mix(1000);
  endtask

  task automatic test_pattern_stalls();
    ready_mode   = READY_PATTERN;
    sender_gappy = 1'b1;
    send_random_mix(250);
  endtask

  task automatic test_full_rate();
    ready_mode   = READY_ALWAYS;
    sender_gappy = 1'b0;
    send_random_mix(200);
  endtask

  // Receiver stops for a long stretch while bytes keep coming; frames pile
  // up against the output register and the input has to back off.
  task automatic test_backpressure();
    ready_mode    = READY_RANDOM;
    sender_gappy  = 1'b0;
    hold_off_left = 400;
    send_random_mix(150);
    sender_gappy  = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int guard;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_frames();
    test_random_frames();
    test_pattern_stalls();
    test_full_rate();
    test_backpressure();
    idle_input();

    guard = 0;
    while (expected_frames.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    if (expected_frames.size() != 0)
      report_mismatch($sformatf("%0d expected frames never arrived",
                                expected_frames.size()));
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** signed_coordinate_frame_parser: PASSED **");
    end else begin
      $display("** signed_coordinate_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
